[src/hss_pkg.sv]
// ----------------------------------------------------------------------------
// hss_pkg
// Types and constants shared by the three-axis half-step sequencer.
// ----------------------------------------------------------------------------
package hss_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] phase_type;
   typedef logic [3:0] coil_type;
   typedef logic [1:0] power_type;

   localparam byte_type  SPEED_CMD   = 8'hC0;
   localparam byte_type  POWER_MASK  = 8'hFC;
   localparam byte_type  POWER_CMD   = 8'hA0;
   localparam byte_type  CMD_ECHO    = 8'h7F;
   localparam byte_type  DELAY_RESET = 8'd16;
   localparam power_type POWER_RESET = 2'b11;
   localparam int        CMD_BIT     = 7;

   // half-step coil pattern for each phase
   function automatic coil_type coil_of(input phase_type phase);
      coil_type coil;
      case (phase)
         3'd0:    coil = 4'h9;
         3'd1:    coil = 4'h8;
         3'd2:    coil = 4'hC;
         3'd3:    coil = 4'h4;
         3'd4:    coil = 4'h6;
         3'd5:    coil = 4'h2;
         3'd6:    coil = 4'h3;
         default: coil = 4'h1;
      endcase
      return coil;
   endfunction

endpackage

[src/hss_axis.sv]
// ----------------------------------------------------------------------------
// hss_axis
// One motor axis: phase register moved a half step forward or back, and the
// coil pattern of the phase it moves to.
// ----------------------------------------------------------------------------
module hss_axis (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               fwd,
   input  logic               back,
   output hss_pkg::coil_type  coil_next
);
   import hss_pkg::*;

   phase_type phase_ff;
   phase_type phase_in;

   always_comb begin
      phase_in = phase_ff;
      if (step_en) begin
         // forward and back on the same axis cancel
         if (fwd && !back) begin
            phase_in = phase_ff + 3'd1;
         end else if (back && !fwd) begin
            phase_in = phase_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign coil_next = coil_of(phase_in);

endmodule

[src/three_axis_half_step_sequencer.sv]
// ----------------------------------------------------------------------------
// three_axis_half_step_sequencer
// Timer-tick and command-byte driven half-step sequencer for three axes.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle (tick or received byte) and presents its
// result in the cycle after acceptance from a single result register;
// req_ready stays high whenever that register is empty or is being drained,
// so a steady stream sustains one word per cycle. Every word produces exactly
// one result: refused step bytes come back with rsp_accepted low and must be
// resent. Coil patterns and power bits reflect the state after the word.
module three_axis_half_step_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  hss_pkg::byte_type  req_byte_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_echo_valid,
   output hss_pkg::byte_type  rsp_echo_byte,
   output hss_pkg::coil_type  rsp_coil_x,
   output hss_pkg::coil_type  rsp_coil_y,
   output hss_pkg::coil_type  rsp_coil_z,
   output hss_pkg::power_type rsp_power_bits
);
   import hss_pkg::*;

   logic      take;
   logic      is_byte;
   logic      step_byte;
   logic      step_ok;
   logic      step_take;
   logic      cmd_byte;

   byte_type  tick_count_ff, tick_count_in;
   logic      tick_wrapped_ff, tick_wrapped_in;
   byte_type  step_delay_ff, step_delay_in;
   power_type power_state_ff, power_state_in;
   logic      await_speed_ff, await_speed_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      accepted_ff, accepted_in;
   logic      echo_valid_ff, echo_valid_in;
   byte_type  echo_byte_ff, echo_byte_in;
   coil_type  coil_x_ff, coil_y_ff, coil_z_ff;
   coil_type  coil_x_in, coil_y_in, coil_z_in;
   power_type power_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   assign is_byte   = !req_action;
   assign step_byte = is_byte && !req_byte_value[CMD_BIT] && !await_speed_ff;
   assign cmd_byte  = is_byte && !step_byte;
   assign step_ok   = (tick_count_ff >= step_delay_ff) || tick_wrapped_ff;
   assign step_take = take && step_byte && step_ok;

   always_comb begin
      tick_count_in   = tick_count_ff;
      tick_wrapped_in = tick_wrapped_ff;
      step_delay_in   = step_delay_ff;
      power_state_in  = power_state_ff;
      await_speed_in  = await_speed_ff;
      if (take) begin
         if (req_action) begin
            tick_wrapped_in = tick_wrapped_ff || (tick_count_ff == 8'hFF);
            tick_count_in   = tick_count_ff + 8'd1;
         end else if (step_byte) begin
            if (step_ok) begin
               tick_count_in   = '0;
               tick_wrapped_in = 1'b0;
            end
         end else if (await_speed_ff) begin
            step_delay_in  = req_byte_value;
            await_speed_in = 1'b0;
         end else if (req_byte_value == SPEED_CMD) begin
            await_speed_in = 1'b1;
         end else if ((req_byte_value & POWER_MASK) == POWER_CMD) begin
            power_state_in = req_byte_value[1:0];
         end
      end
   end

   always_comb begin
      accepted_in   = !(step_byte && !step_ok);
      echo_valid_in = (step_byte && step_ok) || cmd_byte;
      if (step_byte && step_ok) begin
         echo_byte_in = req_byte_value;
      end else if (cmd_byte) begin
         echo_byte_in = CMD_ECHO;
      end else begin
         echo_byte_in = '0;
      end
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   hss_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_take),
      .fwd       (req_byte_value[0]),
      .back      (req_byte_value[3]),
      .coil_next (coil_x_in)
   );

   hss_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_take),
      .fwd       (req_byte_value[1]),
      .back      (req_byte_value[4]),
      .coil_next (coil_y_in)
   );

   hss_axis u_axis_z (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_take),
      .fwd       (req_byte_value[2]),
      .back      (req_byte_value[5]),
      .coil_next (coil_z_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         tick_wrapped_ff <= 1'b0;
         step_delay_ff   <= DELAY_RESET;
         power_state_ff  <= POWER_RESET;
         await_speed_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tick_count_ff   <= tick_count_in;
         tick_wrapped_ff <= tick_wrapped_in;
         step_delay_ff   <= step_delay_in;
         power_state_ff  <= power_state_in;
         await_speed_ff  <= await_speed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a word is taken
   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff   <= accepted_in;
         echo_valid_ff <= echo_valid_in;
         echo_byte_ff  <= echo_byte_in;
         coil_x_ff     <= coil_x_in;
         coil_y_ff     <= coil_y_in;
         coil_z_ff     <= coil_z_in;
         power_ff      <= power_state_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_echo_valid = echo_valid_ff;
   assign rsp_echo_byte  = echo_byte_ff;
   assign rsp_coil_x     = coil_x_ff;
   assign rsp_coil_y     = coil_y_ff;
   assign rsp_coil_z     = coil_z_ff;
   assign rsp_power_bits = power_ff;

endmodule

[src/hss_checker.sv]
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks for the half-step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hss_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_accepted,
   input  logic               rsp_echo_valid,
   input  hss_pkg::byte_type  rsp_echo_byte,
   input  hss_pkg::coil_type  rsp_coil_x
);
   import hss_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
         && $stable(rsp_accepted) && $stable(rsp_coil_x))
      else $error("stalled result word changed");

   // every taken word yields a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("taken word produced no result");

   // a refused step carries no echo
   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_echo_valid && (rsp_echo_byte == '0))
      else $error("refused step echoed");

   // echo is either a command acknowledge or a step byte with its top bit clear
   a_echo_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_echo_valid |->
         (rsp_echo_byte == CMD_ECHO) || !rsp_echo_byte[CMD_BIT])
      else $error("echo byte malformed");

endmodule

bind three_axis_half_step_sequencer hss_checker u_hss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_accepted   (rsp_accepted),
   .rsp_echo_valid (rsp_echo_valid),
   .rsp_echo_byte  (rsp_echo_byte),
   .rsp_coil_x     (rsp_coil_x)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis half-step sequencer: ticks, step
// bytes and command bytes go in over a valid/ready channel, and every result
// word is compared against a cycle-free model of phases, tick counter, step
// delay and power bits, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import hss_pkg::*;

   typedef struct packed {
      logic      accepted;
      logic      echo_valid;
      byte_type  echo_byte;
      coil_type  coil_x;
      coil_type  coil_y;
      coil_type  coil_z;
      power_type power_bits;
   } motor_result_type;

   // coil nibble per phase, phase 0 in the low nibble
   localparam logic [31:0] COIL_SEQ = 32'h13264C89;
   localparam int          HOLD_LEN = 300;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   logic      req_action = 1'b0;
   byte_type  req_byte_value = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_accepted;
   logic      rsp_echo_valid;
   byte_type  rsp_echo_byte;
   coil_type  rsp_coil_x;
   coil_type  rsp_coil_y;
   coil_type  rsp_coil_z;
   power_type rsp_power_bits;

   // model state
   phase_type axis_phase [3];
   byte_type  ticks_since_step;
   logic      ticks_rolled;
   byte_type  step_gap;
   power_type power_mode;
   logic      speed_pending;

   motor_result_type pending_results [$];
   int   fail_count = 0;
   int   words_sent = 0;
   logic last_accepted = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_cycles = 0;
   logic hold_request = 1'b0;

   three_axis_half_step_sequencer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_echo_byte  (rsp_echo_byte),
      .rsp_coil_x     (rsp_coil_x),
      .rsp_coil_y     (rsp_coil_y),
      .rsp_coil_z     (rsp_coil_z),
      .rsp_power_bits (rsp_power_bits)
   );

   always #5 clock = ~clock;

   function automatic coil_type coil_for(input phase_type p);
      return COIL_SEQ[{p, 2'b00} +: 4];
   endfunction

   function automatic void clear_sequencer_model();
      axis_phase[0]    = '0;
      axis_phase[1]    = '0;
      axis_phase[2]    = '0;
      ticks_since_step = '0;
      ticks_rolled     = 1'b0;
      step_gap         = DELAY_RESET;
      power_mode       = POWER_RESET;
      speed_pending    = 1'b0;
   endfunction

   function automatic logic step_allowed();
      return (ticks_since_step >= step_gap) || ticks_rolled;
   endfunction

   // applies one accepted word to the model and returns the result it causes
   function automatic motor_result_type advance_sequencer(input logic act,
                                                          input byte_type val);
      motor_result_type r;
      int a;
      r = '0;
      r.accepted = 1'b1;
      if (act) begin
         if (ticks_since_step == 8'hFF) ticks_rolled = 1'b1;
         ticks_since_step = ticks_since_step + 8'd1;
      end else if (!val[CMD_BIT] && !speed_pending) begin
         if (step_allowed()) begin
            // forward first, then back, so both bits on one axis cancel
            for (a = 0; a < 3; a++) begin
               if (val[a]) axis_phase[a] = axis_phase[a] + 3'd1;
               if (val[a + 3]) axis_phase[a] = axis_phase[a] - 3'd1;
            end
            ticks_since_step = '0;
            ticks_rolled     = 1'b0;
            r.echo_valid     = 1'b1;
            r.echo_byte      = val;
         end else begin
            r.accepted = 1'b0;
         end
      end else begin
         if (speed_pending) begin
            step_gap      = val;
            speed_pending = 1'b0;
         end else if (val == SPEED_CMD) begin
            speed_pending = 1'b1;
         end else if ((val & POWER_MASK) == POWER_CMD) begin
            power_mode = val[1:0];
         end
         r.echo_valid = 1'b1;
         r.echo_byte  = CMD_ECHO;
      end
      r.coil_x     = coil_for(axis_phase[0]);
      r.coil_y     = coil_for(axis_phase[1]);
      r.coil_z     = coil_for(axis_phase[2]);
      r.power_bits = power_mode;
      return r;
   endfunction

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_request) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= HOLD_LEN;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      motor_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", int'(want.accepted), int'(rsp_accepted));
            check_field("echo_valid", int'(want.echo_valid), int'(rsp_echo_valid));
            check_field("echo_byte", int'(want.echo_byte), int'(rsp_echo_byte));
            check_field("coil_x", int'(want.coil_x), int'(rsp_coil_x));
            check_field("coil_y", int'(want.coil_y), int'(rsp_coil_y));
            check_field("coil_z", int'(want.coil_z), int'(rsp_coil_z));
            check_field("power_bits", int'(want.power_bits), int'(rsp_power_bits));
         end
      end
   end

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input logic act, input byte_type val);
      motor_result_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_byte_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = advance_sequencer(act, val);
      last_accepted = want.accepted;
      pending_results.push_back(want);
      words_sent++;
   endtask

   task automatic send_tick();
      send_word(1'b1, byte_type'($urandom_range(0, 255)));
   endtask

   task automatic send_command(input byte_type val);
      send_word(1'b0, val);
   endtask

   // a refused step gets ticks until the delay has run out, then goes again
   task automatic send_step_until_taken(input byte_type val);
      send_word(1'b0, val);
      while (!last_accepted) begin
         while (!step_allowed()) send_tick();
         send_word(1'b0, val);
      end
   endtask

   task automatic wait_for_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic byte_type pick_speed();
      int r;
      r = $urandom_range(99);
      if (r < 85) return byte_type'($urandom_range(0, 6));
      if (r < 95) return byte_type'($urandom_range(7, 40));
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic test_refused_after_reset();
      int n;
      send_command(8'h01);                 // refused, no ticks yet
      for (n = 0; n < 15; n++) send_tick();
      send_command(8'h01);                 // one tick short of the delay
      send_tick();
      send_command(8'h01);                 // exactly at the delay
   endtask

   task automatic test_commands();
      send_command(8'hA0);
      send_command(8'hA1);
      send_command(8'hA2);
      send_command(8'hA3);
      send_command(8'hA4);                 // near miss on the power pattern
      send_command(8'hFF);
      send_command(8'h80);
      send_command(SPEED_CMD);
      send_command(8'h05);                 // low byte while waiting is still speed data
      send_command(SPEED_CMD);
      send_command(SPEED_CMD);             // speed command itself as the delay value
      send_command(SPEED_CMD);
      send_command(8'h00);
   endtask

   task automatic test_step_directions();
      send_step_until_taken(8'h01);
      send_step_until_taken(8'h3F);        // every axis both ways cancels
      send_step_until_taken(8'h7F);        // bit 6 has no effect
      send_step_until_taken(8'h40);
      send_step_until_taken(8'h38);
      send_step_until_taken(8'h07);
      send_step_until_taken(8'h12);
      send_step_until_taken(8'h24);
   endtask

   task automatic test_delay_extremes();
      int n;
      send_command(SPEED_CMD);
      send_command(8'hFF);
      for (n = 0; n < 254; n++) send_tick();
      send_command(8'h02);                 // 254 ticks, refused
      send_tick();
      send_command(8'h02);                 // 255 ticks, taken
      for (n = 0; n < 257; n++) send_tick();
      send_command(8'h20);                 // counter past 255: wrap flag lets it in
      send_command(8'h20);                 // refused again right after
   endtask

   // receiver holds off while words keep coming, so the input backs up
   task automatic test_receiver_hold();
      int n;
      send_idle_pct = 0;
      req_valid    <= 1'b0;
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (n = 0; n < 20; n++) send_tick();
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      int stop_at;
      int pick;
      byte_type val;
      stop_at = words_sent + count;
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_tick();
         end else if (pick < 72) begin
            val = byte_type'($urandom_range(0, 127));
            if (!speed_pending && $urandom_range(99) < 85) send_step_until_taken(val);
            else send_command(val);
         end else if (pick < 82) begin
            send_command(SPEED_CMD);
            if (pick < 81) send_command(pick_speed());
         end else if (pick < 91) begin
            send_command(POWER_CMD | byte_type'($urandom_range(0, 3)));
         end else begin
            send_command(8'h80 | byte_type'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      clear_sequencer_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_refused_after_reset();
      test_commands();
      test_step_directions();
      test_delay_extremes();
      test_receiver_hold();
      test_random_traffic(300, 0, 0);
      wait_for_all_results();              // sender pauses until all results are back
      test_random_traffic(300, 63, 0);
      test_random_traffic(300, 0, 63);
      test_random_traffic(300, 17, 17);
      wait_for_all_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("** three_axis_half_step_sequencer: PASSED **");
      end else begin
         $display("** three_axis_half_step_sequencer: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** three_axis_half_step_sequencer: FAILED **");
      $finish;
   end

endmodule
